[sv/gpb_pkg.sv]
// Shared types and constants for the greedy page breaker.
package gpb_pkg;

    // Node kinds
    localparam logic [2:0] KIND_BOX     = 3'd0;
    localparam logic [2:0] KIND_GLUE    = 3'd1;
    localparam logic [2:0] KIND_RULE    = 3'd2;
    localparam logic [2:0] KIND_PENALTY = 3'd3;

    // Configuration register indexes
    localparam logic CFG_PAGE_TARGET     = 1'b0;
    localparam logic CFG_FALLBACK_TARGET = 1'b1;

    // Badness constants in Q16.16: flex 20.0 and delta cap 100.0 (ratio cap 5.0 times the flex)
    localparam logic [22:0] FLEX_Q      = 23'd1310720;
    localparam logic [22:0] RATIO_CAP_Q = 23'd6553600;
    localparam logic [13:0] BAD_MAX     = 14'd10000;
    // ceil(2^18 / 5): exact divide by five for 16-bit operands
    localparam logic [15:0] RECIP5      = 16'd52429;
    // largest value of floor(d^3 / 2^52) with d at the cap
    localparam logic [15:0] CUBE_MAX    = 16'd62500;

    // Badness sequencer steps
    localparam logic [2:0] STEP_NONE  = 3'd0;
    localparam logic [2:0] STEP_DELTA = 3'd1;
    localparam logic [2:0] STEP_SQ    = 3'd2;
    localparam logic [2:0] STEP_LO    = 3'd3;
    localparam logic [2:0] STEP_HI    = 3'd4;
    localparam logic [2:0] STEP_SUM   = 3'd5;
    localparam logic [2:0] STEP_DIV   = 3'd6;

    typedef logic [2:0] t_step;

    typedef struct packed {
        logic  latch;       // capture the incoming request
        logic  place;       // add the node to the running page
        logic  emit;        // close the running page into the snapshot
        logic  emit_final;  // closed page ends the list
        t_step step;        // badness sequencer step
        logic  load_out;    // move snapshot and badness into the output register
    } t_cmd;

    typedef struct packed {
        logic brk;       // node does not fit on the non-empty page
        logic pen_neg;   // node is a negative penalty
        logic last;      // node ends the list
        logic out_free;  // output register can take a page this cycle
    } t_stat;

endpackage

[sv/gpb_ctrl.sv]
// Controller state machine for the greedy page breaker.
module gpb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gpb_pkg::t_stat i_stat,
    output gpb_pkg::t_cmd  o_cmd
);
    import gpb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_EMIT   = 4'd2;
    localparam logic [3:0] S_DELTA  = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_LO     = 4'd5;
    localparam logic [3:0] S_HI     = 4'd6;
    localparam logic [3:0] S_SUM    = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_LOAD   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_fin, n_fin;        // final flag of the pending emit
    logic       r_second, n_second;  // one-node final page still to emit

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_second <= n_second;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_fin    = r_fin;
        n_second = r_second;
        o_cmd    = '0;
        o_cmd.step = STEP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_stat.brk && i_stat.pen_neg) begin
                    // negative penalty joins the closing page
                    o_cmd.place = 1'b1;
                    n_fin       = i_stat.last;
                    n_second    = 1'b0;
                    n_state     = S_EMIT;
                end else if (i_stat.brk) begin
                    // close the page, node opens the next one
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_final = 1'b0;
                    o_cmd.place      = 1'b1;
                    n_second         = i_stat.last;
                    n_state          = S_DELTA;
                end else begin
                    o_cmd.place = 1'b1;
                    n_fin       = 1'b1;
                    n_second    = 1'b0;
                    n_state     = i_stat.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit       = 1'b1;
                o_cmd.emit_final = r_fin;
                n_state          = S_DELTA;
            end
            S_DELTA: begin
                o_cmd.step = STEP_DELTA;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.step = STEP_SQ;
                n_state    = S_LO;
            end
            S_LO: begin
                o_cmd.step = STEP_LO;
                n_state    = S_HI;
            end
            S_HI: begin
                o_cmd.step = STEP_HI;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.step = STEP_SUM;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = STEP_DIV;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (r_second) begin
                        n_second = 1'b0;
                        n_fin    = 1'b1;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[sv/gpb_dpath.sv]
// Datapath: running page, page snapshot, badness unit and output register.
module gpb_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [30:0]    i_cfg_data,
    input  logic [2:0]     i_node_kind,
    input  logic [31:0]    i_extent,
    input  logic [31:0]    i_depth,
    input  logic [31:0]    i_penalty_value,
    input  logic           i_end_of_list,
    input  gpb_pkg::t_cmd  i_cmd,
    output gpb_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [15:0]    o_page_number,
    output logic [15:0]    o_node_count,
    output logic [31:0]    o_page_height,
    output logic [13:0]    o_page_badness,
    output logic           o_final_page
);
    import gpb_pkg::*;

    localparam logic signed [32:0] NegFlex = -$signed({10'b0, FLEX_Q});

    // configuration
    logic [30:0] r_page_target, r_fallback_target;
    logic [30:0] w_target;

    // captured request
    logic signed [33:0] r_space;
    logic               r_pen_neg, r_last;
    logic signed [33:0] w_space;

    // running page
    logic signed [31:0] r_height;
    logic [15:0]        r_count, r_pgnum;

    // closed page snapshot
    logic signed [31:0] r_pg_height;
    logic [15:0]        r_pg_count, r_pg_num;
    logic               r_pg_final;

    // badness unit
    logic [22:0] r_d;
    logic        r_zero, r_over;
    logic [45:0] r_sq, r_plo, r_phi;
    logic [15:0] r_v;
    logic [13:0] r_bad;

    // output register
    logic               r_out_valid;
    logic [15:0]        r_out_num, r_out_cnt;
    logic [31:0]        r_out_hgt;
    logic [13:0]        r_out_bad;
    logic               r_out_fin;

    logic signed [34:0] w_fit_sum, w_place_sum;
    logic signed [31:0] w_base_h, w_place_h;
    logic [15:0]        w_base_c;
    logic signed [32:0] w_delta;
    logic [32:0]        w_abs;
    logic [22:0]        w_mul_a, w_mul_b;
    logic [45:0]        w_prod;
    logic [68:0]        w_cube;
    logic [13:0]        w_q;

    assign w_target = (r_page_target != '0) ? r_page_target : r_fallback_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_target     <= '0;
            r_fallback_target <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAGE_TARGET:     r_page_target     <= i_cfg_data;
                CFG_FALLBACK_TARGET: r_fallback_target <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // space a node takes on the page
    always_comb begin
        unique case (i_node_kind)
            KIND_BOX, KIND_RULE:
                w_space = {{2{i_extent[31]}}, i_extent} + {{2{i_depth[31]}}, i_depth};
            KIND_GLUE:
                w_space = {{2{i_extent[31]}}, i_extent};
            default:
                w_space = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_space   <= w_space;
            r_pen_neg <= (i_node_kind == KIND_PENALTY) && i_penalty_value[31];
            r_last    <= i_end_of_list;
        end
    end

    // break test on the exact sum
    assign w_fit_sum = {{3{r_height[31]}}, r_height} + {r_space[33], r_space};
    assign o_stat.brk     = (r_count != '0) && (w_fit_sum > $signed({4'b0, w_target}));
    assign o_stat.pen_neg = r_pen_neg;
    assign o_stat.last    = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // placement starts from an empty page when the page closes in the same cycle
    assign w_base_h    = i_cmd.emit ? '0 : r_height;
    assign w_base_c    = i_cmd.emit ? '0 : r_count;
    assign w_place_sum = {{3{w_base_h[31]}}, w_base_h} + {r_space[33], r_space};

    always_comb begin
        if (w_place_sum > 35'sh7FFFFFFF)
            w_place_h = 32'sh7FFFFFFF;
        else if (w_place_sum < -35'sh80000000)
            w_place_h = 32'sh80000000;
        else
            w_place_h = w_place_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
            r_count  <= '0;
            r_pgnum  <= '0;
        end else begin
            if (i_cmd.place) begin
                r_height <= w_place_h;
                r_count  <= (w_base_c == 16'hFFFF) ? w_base_c : w_base_c + 16'd1;
            end else if (i_cmd.emit) begin
                r_height <= '0;
                r_count  <= '0;
            end
            if (i_cmd.emit)
                r_pgnum <= i_cmd.emit_final ? '0 : r_pgnum + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pg_height <= r_height;
            r_pg_count  <= r_count;
            r_pg_num    <= r_pgnum;
            r_pg_final  <= i_cmd.emit_final;
        end
    end

    // badness: d^3 / (5 * 2^52), limited to BAD_MAX, with one shared 23x23 multiplier
    assign w_delta = $signed({2'b0, w_target}) - $signed({r_pg_height[31], r_pg_height});
    assign w_abs   = w_delta[32] ? 33'(-w_delta) : 33'(w_delta);

    always_comb begin
        unique case (i_cmd.step)
            STEP_SQ: begin
                w_mul_a = r_d;
                w_mul_b = r_d;
            end
            STEP_LO: begin
                w_mul_a = r_sq[22:0];
                w_mul_b = r_d;
            end
            STEP_HI: begin
                w_mul_a = r_sq[45:23];
                w_mul_b = r_d;
            end
            STEP_DIV: begin
                w_mul_a = {7'b0, r_v};
                w_mul_b = {7'b0, RECIP5};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_cube = {r_phi, 23'b0} + {23'b0, r_plo};
    assign w_q    = w_prod[31:18];

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.step)
            STEP_DELTA: begin
                r_zero <= (w_delta == '0);
                r_over <= (w_delta < NegFlex);
                r_d    <= (w_abs > {10'b0, RATIO_CAP_Q}) ? RATIO_CAP_Q : w_abs[22:0];
            end
            STEP_SQ:  r_sq  <= w_prod;
            STEP_LO:  r_plo <= w_prod;
            STEP_HI:  r_phi <= w_prod;
            STEP_SUM: r_v   <= w_cube[67:52];
            STEP_DIV: begin
                if (r_zero)
                    r_bad <= '0;
                else if (r_over || (w_q > BAD_MAX))
                    r_bad <= BAD_MAX;
                else
                    r_bad <= w_q;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_num <= r_pg_num;
            r_out_cnt <= r_pg_count;
            r_out_hgt <= r_pg_height;
            r_out_bad <= r_bad;
            r_out_fin <= r_pg_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_number  = r_out_num;
    assign o_node_count   = r_out_cnt;
    assign o_page_height  = r_out_hgt;
    assign o_page_badness = r_out_bad;
    assign o_final_page   = r_out_fin;

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_count != '0))
        else $error("page closed with no nodes");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_cube_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == STEP_DIV) |-> (r_v <= CUBE_MAX))
        else $error("cube exceeds capped ratio");

    a_bad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_out_bad <= BAD_MAX))
        else $error("badness above limit");

endmodule

[sv/greedy_page_breaker_top.sv]
// Top level of the greedy page breaker: controller plus datapath.
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  -----------------------------------------
//  in        input      i_in_valid / o_in_ready     i_node_kind, i_extent, i_depth,
//                                                   i_penalty_value, i_end_of_list
//  out       output     o_out_valid / i_out_ready   o_page_number, o_node_count,
//                                                   o_page_height, o_page_badness, o_final_page
//  cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// A node that closes no page goes through accept and fit test. A closed page then goes through
// the badness sequencer (6 steps, the square, partial products and divide by five sharing one
// 23x23 multiplier, then the load), after an emit step of its own when it is not closed in the
// fit test. One request is in flight; the output register holds a page while the next
// request is accepted, and a full output register stalls the final load step. Reset is
// synchronous, active low: clears running page, page index, targets and output valid.
module greedy_page_breaker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data,
    // node requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_node_kind,
    input  logic [31:0] i_extent,
    input  logic [31:0] i_depth,
    input  logic [31:0] i_penalty_value,
    input  logic        i_end_of_list,
    // closed pages
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_page_number,
    output logic [15:0] o_node_count,
    output logic [31:0] o_page_height,
    output logic [13:0] o_page_badness,
    output logic        o_final_page
);
    import gpb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: accept, fit test, page close and badness steps.
    gpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Running page, snapshot of the closed page, badness arithmetic, output register.
    gpb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_node_kind     (i_node_kind),
        .i_extent        (i_extent),
        .i_depth         (i_depth),
        .i_penalty_value (i_penalty_value),
        .i_end_of_list   (i_end_of_list),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_page_number   (o_page_number),
        .o_node_count    (o_node_count),
        .o_page_height   (o_page_height),
        .o_page_badness  (o_page_badness),
        .o_final_page    (o_final_page)
    );

endmodule
